/* hdl/bhp_pkg.sv */
// Shared types and constants of the branch history predictor.
`default_nettype none

package bhp_pkg;

   localparam int unsigned TABLE_ENTRIES = 1024;   // power of two, 16 to 65536
   localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int unsigned TAG_W         = 30;
   localparam int unsigned QUEUE_DEPTH   = 2;
   localparam int unsigned QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W        = $clog2(QUEUE_DEPTH + 1);

   localparam logic [6:0] OPCODE_MASK   = 7'h7F;
   localparam logic [6:0] BRANCH_OPCODE = 7'h63;

   localparam logic [1:0] SEEN_NONE = 2'd0;
   localparam logic [1:0] SEEN_ONE  = 2'd1;
   localparam logic [1:0] SEEN_TWO  = 2'd2;

   // A classified branch on its way from the front to the back.
   typedef struct packed {
      logic [31:0] inst_pc;
      logic [31:0] taken_target;
      logic [31:0] fall_through;
      logic [31:0] actual_next_pc;
   } bhp_item_type;

   // One history table row.
   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic [1:0]       seen;
      logic [1:0]       outcomes;   // bit 0 last, bit 1 older; 1 = taken
   } bhp_entry_type;

   localparam int unsigned ENTRY_W = $bits(bhp_entry_type);

   typedef struct packed {
      logic valid;
      logic full;
   } bhp_queue_status_type;

   typedef struct packed {
      logic clearing;
   } bhp_back_status_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE
   } bhp_back_state_type;

endpackage

`default_nettype wire

/* hdl/bhp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bhp_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/bhp_front.sv */
// Front end: accept transactions, drop non-branches, form both targets.
`default_nettype none

module bhp_front
   import bhp_pkg::*;
(
   input  wire logic         start,
   input  wire logic         busy,
   input  wire logic [31:0]  inst_pc,
   input  wire logic [31:0]  inst_word,
   input  wire logic [31:0]  actual_next_pc,
   output logic              push,
   output bhp_item_type      item
);

   logic        is_branch;
   logic [31:0] offset;

   assign is_branch = (inst_word[6:0] & OPCODE_MASK) == BRANCH_OPCODE;

   // B-type immediate, sign-extended from bit 12
   assign offset = {{19{inst_word[31]}}, inst_word[31], inst_word[7],
                    inst_word[30:25], inst_word[11:8], 1'b0};

   assign push = start && !busy && is_branch;

   always_comb begin
      item.inst_pc        = inst_pc;
      item.taken_target   = inst_pc + offset;
      item.fall_through   = inst_pc + 32'd4;
      item.actual_next_pc = actual_next_pc;
   end

endmodule

`default_nettype wire

/* hdl/bhp_queue.sv */
// Short queue of classified branches between front and back.
`default_nettype none

module bhp_queue
   import bhp_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push,
   input  wire bhp_item_type   push_item,
   input  wire logic           pop,
   output bhp_item_type        head_item,
   output bhp_queue_status_type status
);

   bhp_item_type      slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign status.valid = count_ff != '0;
   assign status.full  = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && status.valid;
   assign head_item    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

/* hdl/bhp_back.sv */
// Back end: history table lookup and update, hit counters, result register.
`default_nettype none

module bhp_back
   import bhp_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire bhp_queue_status_type q_status,
   input  wire bhp_item_type   q_item,
   output logic                q_pop,
   output bhp_back_status_type status,
   output logic                rsp_strobe,
   output logic [31:0]         rsp_taken_target,
   output logic [31:0]         rsp_fall_through,
   output logic [31:0]         rsp_last_outcome_guess,
   output logic [31:0]         rsp_older_outcome_guess,
   output logic                rsp_taken_hit,
   output logic                rsp_fall_hit,
   output logic                rsp_last_hit,
   output logic                rsp_older_hit,
   output logic [31:0]         rsp_taken_total,
   output logic [31:0]         rsp_fall_total,
   output logic [31:0]         rsp_last_total,
   output logic [31:0]         rsp_older_total
);

   bhp_back_state_type state_ff, state_in;
   logic [IDX_W-1:0]   clear_idx_ff, clear_idx_in;
   bhp_item_type       item_ff, item_in;
   logic [31:0]        count_ff [4];
   logic [31:0]        count_in [4];

   logic               strobe_ff, strobe_in;
   logic [31:0]        last_guess_ff, last_guess_in;
   logic [31:0]        older_guess_ff, older_guess_in;
   logic [31:0]        taken_ff, taken_in;
   logic [31:0]        fall_ff, fall_in;
   logic [3:0]         hits_ff, hits_in;

   logic               ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0]   ram_wr_addr, ram_rd_addr;
   bhp_entry_type      ram_wr_data, ram_rd_data;

   logic               tag_hit;
   logic [1:0]         hist;
   logic [1:0]         seen;
   logic [31:0]        g_last, g_older;
   logic [3:0]         hits;
   logic               outcome;
   bhp_entry_type      new_entry;

   bhp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Lookup result of the branch held in item_ff
   assign tag_hit = (ram_rd_data.seen != SEEN_NONE) &&
                    (ram_rd_data.tag == item_ff.inst_pc[31:2]);
   assign hist    = tag_hit ? ram_rd_data.outcomes : 2'b00;
   assign seen    = tag_hit ? ram_rd_data.seen : SEEN_NONE;
   assign g_last  = hist[0] ? item_ff.taken_target : item_ff.fall_through;
   assign g_older = (seen == SEEN_TWO && hist[1]) ? item_ff.taken_target
                                                  : item_ff.fall_through;
   assign hits[0] = item_ff.taken_target == item_ff.actual_next_pc;
   assign hits[1] = item_ff.fall_through == item_ff.actual_next_pc;
   assign hits[2] = g_last == item_ff.actual_next_pc;
   assign hits[3] = g_older == item_ff.actual_next_pc;
   assign outcome = item_ff.actual_next_pc != item_ff.fall_through;

   always_comb begin
      new_entry.tag      = item_ff.inst_pc[31:2];
      new_entry.outcomes = {hist[0], outcome};
      new_entry.seen     = (seen == SEEN_TWO) ? SEEN_TWO : seen + 2'd1;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clear_idx_ff == IDX_W'(TABLE_ENTRIES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_status.valid) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Outputs and datapath controls
   always_comb begin
      q_pop          = 1'b0;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = clear_idx_ff;
      ram_wr_data    = '0;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = q_item.inst_pc[IDX_W+1:2];
      clear_idx_in   = clear_idx_ff;
      item_in        = item_ff;
      count_in       = count_ff;
      strobe_in      = 1'b0;
      taken_in       = taken_ff;
      fall_in        = fall_ff;
      last_guess_in  = last_guess_ff;
      older_guess_in = older_guess_ff;
      hits_in        = hits_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en    = 1'b1;
            clear_idx_in = clear_idx_ff + IDX_W'(1);
         end
         ST_IDLE: begin
            if (q_status.valid) begin
               ram_rd_en = 1'b1;
               q_pop     = 1'b1;
               item_in   = q_item;
            end
         end
         ST_UPDATE: begin
            ram_wr_en      = 1'b1;
            ram_wr_addr    = item_ff.inst_pc[IDX_W+1:2];
            ram_wr_data    = new_entry;
            strobe_in      = 1'b1;
            taken_in       = item_ff.taken_target;
            fall_in        = item_ff.fall_through;
            last_guess_in  = g_last;
            older_guess_in = g_older;
            hits_in        = hits;
            for (int k = 0; k < 4; k++) begin
               if (hits[k]) begin
                  count_in[k] = count_ff[k] + 32'd1;
               end
            end
         end
         default: begin
            ram_wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_idx_ff <= '0;
         strobe_ff    <= 1'b0;
         for (int k = 0; k < 4; k++) begin
            count_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clear_idx_ff <= clear_idx_in;
         strobe_ff    <= strobe_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff        <= item_in;
      taken_ff       <= taken_in;
      fall_ff        <= fall_in;
      last_guess_ff  <= last_guess_in;
      older_guess_ff <= older_guess_in;
      hits_ff        <= hits_in;
   end

   assign status.clearing         = state_ff == ST_CLEAR;
   assign rsp_strobe              = strobe_ff;
   assign rsp_taken_target        = taken_ff;
   assign rsp_fall_through        = fall_ff;
   assign rsp_last_outcome_guess  = last_guess_ff;
   assign rsp_older_outcome_guess = older_guess_ff;
   assign rsp_taken_hit           = hits_ff[0];
   assign rsp_fall_hit            = hits_ff[1];
   assign rsp_last_hit            = hits_ff[2];
   assign rsp_older_hit           = hits_ff[3];
   assign rsp_taken_total         = count_ff[0];
   assign rsp_fall_total          = count_ff[1];
   assign rsp_last_total          = count_ff[2];
   assign rsp_older_total         = count_ff[3];

endmodule

`default_nettype wire

/* hdl/branch_history_predictor_core.sv */
// Top level of the branch history predictor: front, queue and back joined.
//
//   channel   ports                    handshake
//   --------  -----------------------  ---------------------------------------
//   request   start, busy, req_*       transaction taken when start && !busy
//   result    rsp_strobe, rsp_*        one cycle per result, cannot be stalled
//
// A non-branch is dropped in the front. A branch occupies the back for a
// table read, then a compare and table write, and the back takes no new
// branch until both are done; the result registers load with the write.
// A two-entry queue lets the front take new transactions while the back
// works; busy rises when it is full. After reset a clearing pass writes
// every table row, with busy high throughout.
`default_nettype none

module branch_history_predictor_core
   import bhp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [31:0] req_inst_pc,
   input  wire logic [31:0] req_inst_word,
   input  wire logic [31:0] req_actual_next_pc,
   output logic             rsp_strobe,
   output logic [31:0]      rsp_taken_target,
   output logic [31:0]      rsp_fall_through,
   output logic [31:0]      rsp_last_outcome_guess,
   output logic [31:0]      rsp_older_outcome_guess,
   output logic             rsp_taken_hit,
   output logic             rsp_fall_hit,
   output logic             rsp_last_hit,
   output logic             rsp_older_hit,
   output logic [31:0]      rsp_taken_total,
   output logic [31:0]      rsp_fall_total,
   output logic [31:0]      rsp_last_total,
   output logic [31:0]      rsp_older_total
);

   logic                 push;
   bhp_item_type         push_item;
   bhp_item_type         head_item;
   logic                 pop;
   bhp_queue_status_type q_status;
   bhp_back_status_type  back_status;

   // Hold off new transactions during the clearing pass or when the queue is full
   assign busy = back_status.clearing || q_status.full;

   bhp_front u_front (
      .start          (start),
      .busy           (busy),
      .inst_pc        (req_inst_pc),
      .inst_word      (req_inst_word),
      .actual_next_pc (req_actual_next_pc),
      .push           (push),
      .item           (push_item)
   );

   bhp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .status    (q_status)
   );

   bhp_back u_back (
      .clock                   (clock),
      .reset                   (reset),
      .q_status                (q_status),
      .q_item                  (head_item),
      .q_pop                   (pop),
      .status                  (back_status),
      .rsp_strobe              (rsp_strobe),
      .rsp_taken_target        (rsp_taken_target),
      .rsp_fall_through        (rsp_fall_through),
      .rsp_last_outcome_guess  (rsp_last_outcome_guess),
      .rsp_older_outcome_guess (rsp_older_outcome_guess),
      .rsp_taken_hit           (rsp_taken_hit),
      .rsp_fall_hit            (rsp_fall_hit),
      .rsp_last_hit            (rsp_last_hit),
      .rsp_older_hit           (rsp_older_hit),
      .rsp_taken_total         (rsp_taken_total),
      .rsp_fall_total          (rsp_fall_total),
      .rsp_last_total          (rsp_last_total),
      .rsp_older_total         (rsp_older_total)
   );

endmodule

`default_nettype wire

/* dv/testbench.sv */
// Self-checking testbench for the branch history predictor core.
module testbench;
   import bhp_pkg::*;

   localparam int unsigned STALL_LIMIT   = 4000;   // clearing pass plus longest gap, padded
   localparam int unsigned DRAIN_CYCLES  = 20;
   localparam int unsigned RANDOM_ITEMS  = 1928;
   localparam int unsigned POOL_SIZE     = 32;

   // One traced instruction waiting to be driven.
   typedef struct packed {
      logic [31:0] pc;
      logic [31:0] word;
      logic [31:0] actual;
   } trace_type;

   // Everything the block reports for one branch.
   typedef struct packed {
      logic [31:0] taken_target;
      logic [31:0] fall_through;
      logic [31:0] last_guess;
      logic [31:0] older_guess;
      logic        taken_hit;
      logic        fall_hit;
      logic        last_hit;
      logic        older_hit;
      logic [31:0] taken_total;
      logic [31:0] fall_total;
      logic [31:0] last_total;
      logic [31:0] older_total;
   } branch_guess_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [31:0] req_inst_pc = '0;
   logic [31:0] req_inst_word = '0;
   logic [31:0] req_actual_next_pc = '0;
   logic        busy;
   logic        rsp_strobe;
   logic [31:0] rsp_taken_target;
   logic [31:0] rsp_fall_through;
   logic [31:0] rsp_last_outcome_guess;
   logic [31:0] rsp_older_outcome_guess;
   logic        rsp_taken_hit;
   logic        rsp_fall_hit;
   logic        rsp_last_hit;
   logic        rsp_older_hit;
   logic [31:0] rsp_taken_total;
   logic [31:0] rsp_fall_total;
   logic [31:0] rsp_last_total;
   logic [31:0] rsp_older_total;

   trace_type        trace_fifo[$];
   branch_guess_type guesses_due[$];

   // Shadow of the history table and the hit totals.
   logic [TAG_W-1:0] row_tag  [TABLE_ENTRIES];
   logic [1:0]       row_seen [TABLE_ENTRIES];
   logic [1:0]       row_hist [TABLE_ENTRIES];
   logic [31:0]      hit_total[4];

   logic        took_item = 1'b0;
   int unsigned gap_left = 0;
   int unsigned calm_left = 0;
   int unsigned idle_cycles = 0;
   int unsigned fails = 0;

   branch_history_predictor_core u_top (
      .clock                   (clock),
      .reset                   (reset),
      .start                   (start),
      .busy                    (busy),
      .req_inst_pc             (req_inst_pc),
      .req_inst_word           (req_inst_word),
      .req_actual_next_pc      (req_actual_next_pc),
      .rsp_strobe              (rsp_strobe),
      .rsp_taken_target        (rsp_taken_target),
      .rsp_fall_through        (rsp_fall_through),
      .rsp_last_outcome_guess  (rsp_last_outcome_guess),
      .rsp_older_outcome_guess (rsp_older_outcome_guess),
      .rsp_taken_hit           (rsp_taken_hit),
      .rsp_fall_hit            (rsp_fall_hit),
      .rsp_last_hit            (rsp_last_hit),
      .rsp_older_hit           (rsp_older_hit),
      .rsp_taken_total         (rsp_taken_total),
      .rsp_fall_total          (rsp_fall_total),
      .rsp_last_total          (rsp_last_total),
      .rsp_older_total         (rsp_older_total)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 0;
   end

   // Sign-extend a 13-bit branch offset.
   function automatic logic [31:0] sext13(input logic [12:0] off);
      return {{19{off[12]}}, off};
   endfunction

   // Encode a B-type instruction with the given offset (bit 0 ignored).
   function automatic logic [31:0] make_branch(input logic [12:0] off, input logic [2:0] funct3,
                                               input logic [4:0] rs1, input logic [4:0] rs2);
      return {off[12], off[10:5], rs2, rs1, funct3, off[4:1], off[11], 7'(BRANCH_OPCODE)};
   endfunction

   function automatic void push_trace(input logic [31:0] pc, input logic [31:0] word,
                                      input logic [31:0] actual);
      trace_type t;
      t.pc     = pc;
      t.word   = word;
      t.actual = actual;
      trace_fifo = {trace_fifo, t};
   endfunction

   // Work out what the block must report for one transaction; return 0 for a non-branch.
   // Advance the shadow table and totals as a side effect.
   function automatic bit judge_branch(input logic [31:0] pc, input logic [31:0] word,
                                       input logic [31:0] actual, output branch_guess_type g);
      logic [31:0]      offset;
      logic [TAG_W-1:0] tag;
      logic [IDX_W-1:0] idx;
      logic [1:0]       seen;
      logic [1:0]       hist;
      logic             went;
      g = '0;
      if ((word[6:0] & OPCODE_MASK) != BRANCH_OPCODE)
         return 1'b0;
      offset = {{19{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
      g.taken_target = pc + offset;
      g.fall_through = pc + 32'd4;
      tag  = pc[31:2];
      idx  = tag[IDX_W-1:0];
      seen = SEEN_NONE;
      hist = 2'b00;
      // A tag mismatch or an empty row counts as the first encounter.
      if (row_seen[idx] != SEEN_NONE && row_tag[idx] == tag) begin
         seen = row_seen[idx];
         hist = row_hist[idx];
      end
      g.last_guess  = (seen >= SEEN_ONE && hist[0]) ? g.taken_target : g.fall_through;
      g.older_guess = (seen >= SEEN_TWO && hist[1]) ? g.taken_target : g.fall_through;
      g.taken_hit = (g.taken_target == actual);
      g.fall_hit  = (g.fall_through == actual);
      g.last_hit  = (g.last_guess == actual);
      g.older_hit = (g.older_guess == actual);
      hit_total[0] += 32'(g.taken_hit);
      hit_total[1] += 32'(g.fall_hit);
      hit_total[2] += 32'(g.last_hit);
      hit_total[3] += 32'(g.older_hit);
      g.taken_total = hit_total[0];
      g.fall_total  = hit_total[1];
      g.last_total  = hit_total[2];
      g.older_total = hit_total[3];
      went = (actual != g.fall_through);
      row_tag[idx]  = tag;
      row_hist[idx] = {hist[0], went};
      row_seen[idx] = (seen >= SEEN_TWO) ? SEEN_TWO : seen + 2'd1;
      return 1'b1;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %h, actual %h", name, want, got);
         fails++;
      end
   endfunction

   // Pick the idle gap after a transaction: mostly none or short, a few long,
   // and now and then a calm stretch with no gaps at all.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (calm_left != 0) begin
         calm_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
         calm_left = $urandom_range(20, 80);
         return 0;
      end
      if (roll < 50)
         return 0;
      if (roll < 88)
         return $urandom_range(1, 3);
      if (roll < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Driver: change inputs on the falling edge; hold a transaction until taken.
   always @(negedge clock) begin
      trace_type item;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || took_item) begin
         if (gap_left != 0) begin
            start    <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (trace_fifo.size() != 0) begin
            item = trace_fifo.pop_front();
            req_inst_pc        <= item.pc;
            req_inst_word      <= item.word;
            req_actual_next_pc <= item.actual;
            start              <= 1'b1;
            gap_left           <= pick_gap();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: check results first, then predict the transaction taken at this edge.
   always @(posedge clock) begin
      branch_guess_type want;
      branch_guess_type oldest;
      took_item <= start && !busy;
      if (rsp_strobe === 1'b1) begin
         if (guesses_due.size() == 0) begin
            $error("result with no branch outstanding: taken_target %h", rsp_taken_target);
            fails++;
         end else begin
            oldest = guesses_due.pop_front();
            check_field("taken_target", oldest.taken_target, rsp_taken_target);
            check_field("fall_through", oldest.fall_through, rsp_fall_through);
            check_field("last_outcome_guess", oldest.last_guess, rsp_last_outcome_guess);
            check_field("older_outcome_guess", oldest.older_guess, rsp_older_outcome_guess);
            check_field("taken_hit", 32'(oldest.taken_hit), 32'(rsp_taken_hit));
            check_field("fall_hit", 32'(oldest.fall_hit), 32'(rsp_fall_hit));
            check_field("last_hit", 32'(oldest.last_hit), 32'(rsp_last_hit));
            check_field("older_hit", 32'(oldest.older_hit), 32'(rsp_older_hit));
            check_field("taken_total", oldest.taken_total, rsp_taken_total);
            check_field("fall_total", oldest.fall_total, rsp_fall_total);
            check_field("last_total", oldest.last_total, rsp_last_total);
            check_field("older_total", oldest.older_total, rsp_older_total);
         end
      end
      if (!reset && start && busy === 1'b0) begin
         if (judge_branch(req_inst_pc, req_inst_word, req_actual_next_pc, want))
            guesses_due = {guesses_due, want};
      end
   end

   // Watchdog: count cycles with no transaction in either direction.
   always @(posedge clock) begin
      if ((start && busy === 1'b0) || rsp_strobe === 1'b1) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [31:0]  pool_pc  [POOL_SIZE];
      logic [12:0]  pool_off [POOL_SIZE];
      int unsigned  pool_bias[POOL_SIZE];
      logic [31:0]  pc;
      logic [31:0]  word;
      logic [31:0]  actual;
      logic [12:0]  off;
      int unsigned  item_cnt;
      int unsigned  roll;
      int unsigned  k;

      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         row_seen[i] = SEEN_NONE;
         row_hist[i] = 2'b00;
      end
      for (int i = 0; i < 4; i++)
         hit_total[i] = '0;

      // Directed: history build-up on one pc, taken, taken, not taken, taken.
      push_trace(32'h0000_1000, make_branch(13'h0008, 3'd0, 5'd1, 5'd2), 32'h0000_1008);
      push_trace(32'h0000_1000, make_branch(13'h0008, 3'd0, 5'd1, 5'd2), 32'h0000_1008);
      push_trace(32'h0000_1000, make_branch(13'h0008, 3'd0, 5'd1, 5'd2), 32'h0000_1004);
      push_trace(32'h0000_1000, make_branch(13'h0008, 3'd0, 5'd1, 5'd2), 32'h0000_1008);
      // Non-branches: drop without a result.
      push_trace(32'h0000_1004, 32'h0000_0013, 32'h0000_1008);
      push_trace(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_trace(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      push_trace(32'h0000_2000, 32'h0000_006F, 32'h0000_2100);
      push_trace(32'h0000_2004, 32'h0000_0062, 32'h0000_2008);
      // Largest forward offset, pc+4 wrapping to zero.
      push_trace(32'hFFFF_FFFC, make_branch(13'h0FFE, 3'd1, 5'd31, 5'd31), 32'h0000_0000);
      // Largest backward offset from pc zero, wrapping down.
      push_trace(32'h0000_0000, make_branch(13'h1000, 3'd7, 5'd0, 5'd0), 32'hFFFF_F000);
      // Same index, other tag: a tag miss, then the original pc misses in turn.
      push_trace(32'h0000_1000 + 32'(TABLE_ENTRIES * 4), make_branch(13'h0008, 3'd4, 5'd3, 5'd4),
                 32'h0000_1008 + 32'(TABLE_ENTRIES * 4));
      push_trace(32'h0000_1000, make_branch(13'h0008, 3'd0, 5'd1, 5'd2), 32'h0000_1004);
      // Low pc bits are not part of the tag.
      push_trace(32'h0000_1001, make_branch(13'h0008, 3'd0, 5'd1, 5'd2), 32'h0000_1009);
      push_trace(32'h0000_1003, make_branch(13'h0008, 3'd0, 5'd1, 5'd2), 32'h0000_100B);
      push_trace(32'h0000_1002, make_branch(13'h0008, 3'd0, 5'd1, 5'd2), 32'h0000_1006);
      // Offset four: taken target and fall-through coincide.
      push_trace(32'h0000_3000, make_branch(13'h0004, 3'd5, 5'd5, 5'd6), 32'h0000_3004);
      // Actual next pc matches no guess.
      push_trace(32'h0000_3000, make_branch(13'h0004, 3'd5, 5'd5, 5'd6), 32'hA5A5_A5A5);
      // Every word bit set with a branch opcode; bit 7 alone set.
      push_trace(32'h8000_0000, 32'hFFFF_FFE3, 32'h0000_0000);
      push_trace(32'h7FFF_FFFC, 32'h0000_00E3, 32'hFFFF_FFFF);
      // Zero offset from an all-ones pc.
      push_trace(32'hFFFF_FFFF, 32'h0000_0063, 32'hFFFF_FFFF);
      push_trace(32'hFFFF_FFFF, 32'h0000_0063, 32'h0000_0003);

      // Random part: a pool of hot branches, some aliasing on the table index.
      for (int i = 0; i < POOL_SIZE; i++) begin
         if (i < 24)
            pool_pc[i] = 32'h0000_4000 + 32'($urandom_range(0, 63) * 4);
         else
            pool_pc[i] = pool_pc[i - 24] + (32'($urandom_range(1, 7)) << 12);
         pool_off[i]  = 13'($urandom) & 13'h1FFE;
         pool_bias[i] = $urandom_range(0, 100);
      end
      pool_pc[POOL_SIZE - 1] = $urandom & 32'hFFFF_FFFC;
      pool_pc[POOL_SIZE - 2] = 32'hFFFF_F000 + 32'($urandom_range(0, 1023) * 4);

      item_cnt = 0;
      while (item_cnt < RANDOM_ITEMS) begin
         roll = $urandom_range(0, 99);
         if (roll < 15) begin
            // Noise: a random non-branch.
            word = $urandom;
            if (word[6:0] == BRANCH_OPCODE)
               word[0] = ~word[0];
            push_trace($urandom, word, $urandom);
         end else if (roll < 22) begin
            // Noise: a random branch anywhere with a random outcome.
            word = $urandom;
            word[6:0] = BRANCH_OPCODE;
            push_trace($urandom, word, $urandom);
         end else begin
            k  = $urandom_range(0, POOL_SIZE - 1);
            pc = pool_pc[k];
            if ($urandom_range(0, 9) == 0)
               pc[1:0] = 2'($urandom);
            if ($urandom_range(0, 11) == 0) begin
               // A different instruction at a hot pc.
               word = $urandom;
               word[6:0] = BRANCH_OPCODE;
               actual = $urandom_range(0, 1) ? pc + 32'd4 : $urandom;
            end else begin
               off  = pool_off[k];
               word = make_branch(off, 3'($urandom), 5'($urandom), 5'($urandom));
               if ($urandom_range(0, 99) < 6)
                  actual = $urandom;
               else if ($urandom_range(0, 99) < pool_bias[k])
                  actual = pc + sext13(off);
               else
                  actual = pc + 32'd4;
            end
            push_trace(pc, word, actual);
         end
         item_cnt++;
      end

      // Hold reset, then release it.
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Drain: all transactions taken, all results in, then the pipeline tail.
      while (trace_fifo.size() != 0 || start)
         @(posedge clock);
      while (guesses_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fails == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

/* files.f */
hdl/bhp_pkg.sv
hdl/bhp_ram.sv
hdl/bhp_front.sv
hdl/bhp_queue.sv
hdl/bhp_back.sv
hdl/branch_history_predictor_core.sv
dv/testbench.sv
